### sv/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher.
package rc4_pkg;

   localparam int PERM_DEPTH    = 256;
   localparam int MAX_KEY_BYTES = 32;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_KEY_LENGTH   = 3'd0;
   localparam csr_index_type CSR_KEY_LO       = 3'd1;
   localparam csr_index_type CSR_KEY_MID_LO   = 3'd2;
   localparam csr_index_type CSR_KEY_MID_HI   = 3'd3;
   localparam csr_index_type CSR_KEY_HI       = 3'd4;

   // Access bundle from the sequencer datapath to the permutation memory.
   typedef struct packed {
      logic     clr;
      byte_type rd_addr;
      logic     we;
      byte_type wr_addr;
      byte_type wr_data;
   } perm_ctl_type;

endpackage

### sv/rc4_stream_cipher.sv
// RC4 stream cipher top level: microcoded sequencer, key registers and result buffer.
// A request without start of message runs the keystream steps P0..P3; its response is then registered.
// A request with start of message first reruns key scheduling: steps K1..K3 for each permutation
// entry over one memory write port, between KINIT and KEND, before its keystream step.
// Reset (synchronous) sets the identity permutation, zero indices, key length 1, zero key;
// the permutation is cleared through valid bits at once, so no clearing pass is needed.
module rc4_stream_cipher (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rc4_pkg::byte_type      req_data_byte,
   input  logic                   req_start_of_message,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rc4_pkg::byte_type      rsp_out_byte,
   input  logic                   csr_we,
   input  rc4_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wdata
);
   import rc4_pkg::*;

   // The step counter addresses the control store below.
   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT  = 4'd0;
   localparam step_type STEP_P0    = 4'd1;
   localparam step_type STEP_P1    = 4'd2;
   localparam step_type STEP_P2    = 4'd3;
   localparam step_type STEP_P3    = 4'd4;
   localparam step_type STEP_KINIT = 4'd5;
   localparam step_type STEP_K1    = 4'd6;
   localparam step_type STEP_K2    = 4'd7;
   localparam step_type STEP_K3    = 4'd8;
   localparam step_type STEP_KEND  = 4'd9;

   typedef enum logic [2:0] {
      RA_ZERO, RA_I_INC, RA_J_RD, RA_J_RD_KEY, RA_SI_RD, RA_N_INC
   } rd_sel_type;

   typedef enum logic [1:0] {WR_NONE, WR_I_RD, WR_N_RD, WR_J_SI} wr_sel_type;
   typedef enum logic [1:0] {J_HOLD, J_ADD_RD, J_ADD_RD_KEY, J_ZERO} j_op_type;
   typedef enum logic [1:0] {JC_NEXT, JC_GOTO, JC_ACCEPT, JC_LOOP_N} jump_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      j_op_type   j_op;
      logic       inc_i;
      logic       ld_si;
      logic       ld_sj;
      logic       emit;
      logic       restart;
      logic       step_n;
      jump_type   jump;
      step_type   target;
   } ctl_word_type;

   // Control store. The keystream step is P0..P3: read S[i+1], read S[j], swap,
   // and read S[S[i]+S[j]] alongside the first swap write. Key scheduling is
   // K1..K3 per entry: read S[n] to form j, write S[n], write S[j] while the
   // read of the next entry is already issued.
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = '0;
      unique case (step)
         STEP_WAIT: begin
            w.jump   = JC_ACCEPT;
            w.target = STEP_KINIT;
         end
         STEP_P0: begin
            w.inc_i  = 1'b1;
            w.rd_sel = RA_I_INC;
         end
         STEP_P1: begin
            w.ld_si  = 1'b1;
            w.j_op   = J_ADD_RD;
            w.rd_sel = RA_J_RD;
         end
         STEP_P2: begin
            w.ld_sj  = 1'b1;
            w.wr_sel = WR_I_RD;
            w.rd_sel = RA_SI_RD;
         end
         STEP_P3: begin
            w.wr_sel = WR_J_SI;
            w.emit   = 1'b1;
            w.jump   = JC_GOTO;
            w.target = STEP_WAIT;
         end
         STEP_KINIT: begin
            w.restart = 1'b1;
            w.j_op    = J_ZERO;
            w.rd_sel  = RA_ZERO;
         end
         STEP_K1: begin
            w.ld_si  = 1'b1;
            w.j_op   = J_ADD_RD_KEY;
            w.rd_sel = RA_J_RD_KEY;
         end
         STEP_K2: begin
            w.wr_sel = WR_N_RD;
         end
         STEP_K3: begin
            w.wr_sel = WR_J_SI;
            w.step_n = 1'b1;
            w.rd_sel = RA_N_INC;
            w.jump   = JC_LOOP_N;
            w.target = STEP_K1;
         end
         STEP_KEND: begin
            w.j_op   = J_ZERO;
            w.jump   = JC_GOTO;
            w.target = STEP_P0;
         end
         default: begin
            w.jump   = JC_GOTO;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   ctl_word_type cw;
   perm_ctl_type mem_ctl;
   byte_type     rd;

   step_type     pc_ff, pc_in;
   byte_type     i_ff, i_in;
   byte_type     j_ff, j_in;
   byte_type     n_ff, n_in;
   logic [4:0]   kidx_ff, kidx_in;
   byte_type     si_ff, sj_ff, data_ff;
   logic [5:0]   klen_ff, klen_in;
   logic [63:0]  key_ff [4];
   logic [63:0]  key_in [4];
   logic         pend_ff, pend_in;
   byte_type     pend_byte_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     rsp_byte_ff;

   logic         accept;
   logic         out_free;
   byte_type     key_byte;
   byte_type     j_rd;
   byte_type     j_rd_key;
   byte_type     t_addr;
   byte_type     ks_byte;
   byte_type     res_byte;
   logic [5:0]   klen_used;
   logic         kidx_wrap;

   assign cw        = ucode(pc_ff);
   assign req_ready = (pc_ff == STEP_WAIT) && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Key bytes cycle through the used length; zero counts as one and the
   // length saturates at the size of the key store.
   assign klen_used = (klen_ff == 6'd0) ? 6'd1 :
                      (klen_ff > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : klen_ff;
   assign kidx_wrap = (({1'b0, kidx_ff} + 6'd1) == klen_used);
   assign key_byte  = key_ff[kidx_ff[4:3]][{kidx_ff[2:0], 3'b000} +: 8];

   assign j_rd      = j_ff + rd;
   assign j_rd_key  = j_ff + rd + key_byte;

   // S[i] was written in the previous step and is bypassed in the memory; the
   // S[j] write lands in this step, so a hit on j takes the old S[i] directly.
   assign t_addr    = si_ff + sj_ff;
   assign ks_byte   = (t_addr == j_ff) ? si_ff : rd;
   assign res_byte  = data_ff ^ ks_byte;

   always_comb begin
      mem_ctl.clr = cw.restart;
      case (cw.rd_sel)
         RA_I_INC:    mem_ctl.rd_addr = i_ff + 8'd1;
         RA_J_RD:     mem_ctl.rd_addr = j_rd;
         RA_J_RD_KEY: mem_ctl.rd_addr = j_rd_key;
         RA_SI_RD:    mem_ctl.rd_addr = si_ff + rd;
         RA_N_INC:    mem_ctl.rd_addr = n_ff + 8'd1;
         default:     mem_ctl.rd_addr = '0;
      endcase
      mem_ctl.we      = 1'b1;
      mem_ctl.wr_addr = i_ff;
      mem_ctl.wr_data = rd;
      case (cw.wr_sel)
         WR_I_RD: begin
            mem_ctl.wr_addr = i_ff;
            mem_ctl.wr_data = rd;
         end
         WR_N_RD: begin
            mem_ctl.wr_addr = n_ff;
            mem_ctl.wr_data = rd;
         end
         WR_J_SI: begin
            mem_ctl.wr_addr = j_ff;
            mem_ctl.wr_data = si_ff;
         end
         default: begin
            mem_ctl.we = 1'b0;
         end
      endcase
   end

   rc4_perm_mem u_perm (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_data (rd)
   );

   // Sequencer and index registers.
   always_comb begin
      case (cw.jump)
         JC_GOTO:   pc_in = cw.target;
         JC_ACCEPT: pc_in = !accept ? pc_ff :
                            (req_start_of_message ? cw.target : pc_ff + 4'd1);
         JC_LOOP_N: pc_in = (n_ff == 8'hFF) ? pc_ff + 4'd1 : cw.target;
         default:   pc_in = pc_ff + 4'd1;
      endcase

      i_in    = i_ff;
      n_in    = n_ff;
      kidx_in = kidx_ff;
      if (cw.restart) begin
         i_in    = '0;
         n_in    = '0;
         kidx_in = '0;
      end
      if (cw.inc_i) begin
         i_in = i_ff + 8'd1;
      end
      if (cw.step_n) begin
         n_in    = n_ff + 8'd1;
         kidx_in = kidx_wrap ? 5'd0 : kidx_ff + 5'd1;
      end

      case (cw.j_op)
         J_ADD_RD:     j_in = j_rd;
         J_ADD_RD_KEY: j_in = j_rd_key;
         J_ZERO:       j_in = '0;
         default:      j_in = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_WAIT;
         i_ff    <= '0;
         j_ff    <= '0;
         n_ff    <= '0;
         kidx_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         n_ff    <= n_in;
         kidx_ff <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
      end
      if (cw.ld_si) begin
         si_ff <= rd;
      end
      if (cw.ld_sj) begin
         sj_ff <= rd;
      end
   end

   // Configuration registers.
   always_comb begin
      klen_in = klen_ff;
      key_in  = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LENGTH: klen_in   = csr_wdata[5:0];
            CSR_KEY_LO:     key_in[0] = csr_wdata;
            CSR_KEY_MID_LO: key_in[1] = csr_wdata;
            CSR_KEY_MID_HI: key_in[2] = csr_wdata;
            CSR_KEY_HI:     key_in[3] = csr_wdata;
            default:        klen_in   = klen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= 6'd1;
         key_ff  <= '{default: '0};
      end else begin
         klen_ff <= klen_in;
         key_ff  <= key_in;
      end
   end

   // Response register plus one holding slot, so a finished result can wait
   // for the consumer while the next request is accepted.
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pend_ff && out_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (cw.emit) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
         end else begin
            pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && out_free) begin
         rsp_byte_ff <= pend_byte_ff;
      end else if (cw.emit && out_free) begin
         rsp_byte_ff <= res_byte;
      end
      if (cw.emit && !out_free) begin
         pend_byte_ff <= res_byte;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   a_start_schedules: assert property (@(posedge clock) disable iff (reset)
      accept && req_start_of_message |=> pc_ff == STEP_KINIT)
      else $error("start of message did not enter key scheduling");

   a_plain_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_start_of_message |=> pc_ff == STEP_P0)
      else $error("plain request did not enter the keystream step");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_P3 |=> rsp_valid_ff || pend_ff)
      else $error("finished result was dropped");

   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_valid_ff)
      else $error("holding slot full while response register is empty");

   a_schedule_complete: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_KEND |-> n_ff == 8'd0 && $past(pc_ff) == STEP_K3)
      else $error("key scheduling left before covering every entry");

endmodule

### sv/rc4_perm_mem.sv
// Permutation memory of the RC4 cipher with per-entry valid bits and write-first reads.
module rc4_perm_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  rc4_pkg::perm_ctl_type ctl,
   output rc4_pkg::byte_type     rd_data
);
   import rc4_pkg::*;

   byte_type                mem_ff [PERM_DEPTH];
   logic [PERM_DEPTH-1:0]   valid_ff;
   logic [PERM_DEPTH-1:0]   valid_in;
   byte_type                rdat_ff;
   byte_type                raddr_ff;
   logic                    rvalid_ff;
   logic                    byp_ff;
   byte_type                bypd_ff;

   // An entry that was not written since the last clear reads as its own index.
   always_comb begin
      valid_in = ctl.clr ? '0 : valid_ff;
      if (ctl.we) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      rdat_ff   <= mem_ff[ctl.rd_addr];
      raddr_ff  <= ctl.rd_addr;
      rvalid_ff <= valid_ff[ctl.rd_addr] & ~ctl.clr;
      byp_ff    <= ctl.we && (ctl.wr_addr == ctl.rd_addr);
      bypd_ff   <= ctl.wr_data;
   end

   assign rd_data = byp_ff ? bypd_ff : (rvalid_ff ? rdat_ff : raddr_ff);

endmodule

### sim/rc4_response_checker.sv
// Checker for the RC4 stream cipher: predicts each output byte and compares responses in order.
`timescale 1ns / 1ps

module rc4_response_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  rc4_pkg::byte_type      req_data_byte,
   input  logic                   req_start_of_message,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rc4_pkg::byte_type      rsp_out_byte,
   input  logic                   csr_we,
   input  rc4_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);
   import rc4_pkg::*;

   // Shadow copy of the key registers and of the cipher state.
   logic [5:0]  shadow_key_length;
   logic [63:0] shadow_key_words [4];
   byte_type    sbox [PERM_DEPTH];
   byte_type    ptr_i;
   byte_type    ptr_j;

   byte_type    expected_bytes [$];

   function automatic byte_type key_byte_at(int unsigned k);
      return shadow_key_words[(k >> 3) & 3][(k & 7) * 8 +: 8];
   endfunction

   // One keystream step, preceded by key scheduling when a message starts.
   function automatic byte_type cipher_byte(byte_type data, logic sop);
      int unsigned klen;
      int unsigned n;
      byte_type    j;
      byte_type    t;
      byte_type    sum;
      if (sop) begin
         klen = shadow_key_length;
         if (klen == 0) klen = 1;
         if (klen > MAX_KEY_BYTES) klen = MAX_KEY_BYTES;
         for (n = 0; n < PERM_DEPTH; n++) sbox[n] = byte_type'(n);
         j = '0;
         for (n = 0; n < PERM_DEPTH; n++) begin
            j = j + sbox[n] + key_byte_at(n % klen);
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
         end
         ptr_i = '0;
         ptr_j = '0;
      end
      ptr_i = ptr_i + 8'd1;
      ptr_j = ptr_j + sbox[ptr_i];
      t = sbox[ptr_i];
      sbox[ptr_i] = sbox[ptr_j];
      sbox[ptr_j] = t;
      sum = sbox[ptr_i] + sbox[ptr_j];
      return data ^ sbox[sum];
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin
      byte_type want;
      if (reset) begin
         shadow_key_length = 6'd1;
         for (int r = 0; r < 4; r++) shadow_key_words[r] = '0;
         for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = byte_type'(n);
         ptr_i = '0;
         ptr_j = '0;
         expected_bytes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_LENGTH: shadow_key_length   = csr_wdata[5:0];
               CSR_KEY_LO:     shadow_key_words[0] = csr_wdata;
               CSR_KEY_MID_LO: shadow_key_words[1] = csr_wdata;
               CSR_KEY_MID_HI: shadow_key_words[2] = csr_wdata;
               CSR_KEY_HI:     shadow_key_words[3] = csr_wdata;
               default: ;
            endcase
         end
         // Responses are matched before this edge's request is queued.
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte 0x%02h arrived with no request outstanding", rsp_out_byte);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want, rsp_out_byte);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_bytes = {expected_bytes,
                              cipher_byte(req_data_byte, req_start_of_message)};
      end
      outstanding <= expected_bytes.size();
   end

endmodule

### sim/tb_rc4_stream_cipher.sv
// Testbench top for the RC4 stream cipher: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
   import rc4_pkg::*;

   // Register indexes past the end of the map; the block must ignore writes to them.
   localparam csr_index_type CSR_FIRST_UNMAPPED = CSR_KEY_HI + 3'd1;
   // Length of the deliberate response hold-off that backs up the request path.
   localparam int HOLD_CYCLES = 80;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   byte_type      req_data_byte = '0;
   logic          req_start_of_message = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   byte_type      rsp_out_byte;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_KEY_LENGTH;
   logic [63:0]   csr_wdata = '0;

   int mismatch_count;
   int outstanding;

   // Quiet mode turns off random idling on both channels for a stretch of the run.
   bit quiet = 1'b0;
   // Set by the stimulus to ask the response side for one long hold-off.
   bit hold_rsp = 1'b0;

   int requests_sent = 0;
   int messages_started = 0;
   int key_settings = 0;

   always #5 clock = ~clock;

   rc4_stream_cipher u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   rc4_response_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .outstanding          (outstanding)
   );

   // Offer one request and return at the edge where it is accepted. A random gap may come
   // first; valid is only dropped when a gap is taken, so back-to-back requests keep it high.
   task automatic send_request(input byte_type data, input logic sop);
      if (!quiet && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 31) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_start_of_message <= sop;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (sop) messages_started++;
   endtask

   // Stop offering and wait until every queued response has been checked, so that the
   // block is idle and the key registers may be rewritten.
   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // A write lands at the edge this task waits for. The enable is left high so that
   // consecutive writes never lower and raise it within one time step; csr_idle lowers it.
   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic csr_idle();
      csr_we <= 1'b0;
   endtask

   // Program the whole key: the length word first, then the four key byte words.
   task automatic load_key(input logic [63:0] len_word, input logic [63:0] k0,
                           input logic [63:0] k1, input logic [63:0] k2,
                           input logic [63:0] k3);
      csr_write(CSR_KEY_LENGTH, len_word);
      csr_write(CSR_KEY_LO, k0);
      csr_write(CSR_KEY_MID_LO, k1);
      csr_write(CSR_KEY_MID_HI, k2);
      csr_write(CSR_KEY_HI, k3);
      csr_idle();
      key_settings++;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Response side: random back-pressure, none in quiet mode, and one long hold-off on demand.
   // The hold-off is counted here so the request side keeps offering while it runs.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 31);
         end
      end
   end

   // Generous watchdog: roughly four times a run in which every request starts a message.
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int          random_sent;
      int          msg;
      int          msg_len;
      int          pick;
      logic        first_sop;
      logic [63:0] len_word;
      logic [63:0] fill;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any start of message run on the identity permutation with zero indices.
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h5A, 1'b0);
      end_burst();

      // Key scheduling with the reset key: length one, all key bytes zero.
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b0);
      end_burst();

      // Writes past the register map must leave the key alone. Key length zero behaves
      // as length one.
      csr_write(CSR_FIRST_UNMAPPED, '1);
      csr_write(CSR_FIRST_UNMAPPED + 3'd2, random_word());
      load_key(64'd0, 64'h0123_4567_89AB_CDEF, random_word(), random_word(), random_word());
      csr_write(CSR_FIRST_UNMAPPED + 3'd1, '1);
      csr_idle();
      send_request(8'hA5, 1'b1);
      send_request(8'h3C, 1'b0);
      end_burst();

      // An all-ones length word: the six-bit field reads 63 and saturates to the maximum.
      // All key bytes are 0xFF, the top of the unsigned byte range.
      load_key('1, '1, '1, '1, '1);
      send_request(8'hFF, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'h81, 1'b0);
      end_burst();

      // Full-length random key.
      load_key(64'd32, random_word(), random_word(), random_word(), random_word());
      send_request(8'h7E, 1'b1);
      send_request(8'hFF, 1'b0);
      send_request(8'h01, 1'b0);
      end_burst();

      // Single-byte key at the top of the byte range.
      load_key(64'd1, 64'hFF, '0, '0, '0);
      send_request(8'h00, 1'b1);
      end_burst();

      // The classic three-byte key "Key" over the text "Plai".
      load_key(64'd3, 64'h0000_0000_0079_654B, '0, '0, '0);
      send_request(8'h50, 1'b1);
      send_request(8'h6C, 1'b0);
      send_request(8'h61, 1'b0);
      send_request(8'h69, 1'b0);
      end_burst();

      // Back-pressure: after the key is scheduled, the response side stalls for a long
      // stretch while requests keep coming, so the block fills and drops req_ready.
      load_key(64'd16, random_word(), random_word(), random_word(), random_word());
      send_request(byte_type'($urandom_range(0, 255)), 1'b1);
      end_burst();
      hold_rsp = 1'b1;
      repeat (30) send_request(byte_type'($urandom_range(0, 255)), 1'b0);
      end_burst();

      // Random messages. Most start with a fresh key schedule; some continue the old
      // stream, and a few restart the schedule in the middle of a message.
      random_sent = 0;
      msg = 0;
      while (random_sent < 480) begin
         if (msg == 0 || $urandom_range(0, 3) == 0) begin
            end_burst();
            if ($urandom_range(0, 7) == 0) begin
               csr_write(CSR_FIRST_UNMAPPED + csr_index_type'($urandom_range(0, 2)),
                         random_word());
            end
            pick = $urandom_range(0, 9);
            fill = random_word();
            case (pick)
               0: len_word = {random_word()} & ~64'h3F;
               1: len_word = 64'($urandom_range(33, 63));
               2: len_word = 64'd32;
               default: len_word = 64'($urandom_range(1, 32));
            endcase
            if (pick == 2) begin
               fill = ($urandom_range(0, 1) != 0) ? '1 : '0;
               load_key(len_word, fill, fill, fill, fill);
            end else begin
               load_key(len_word, random_word(), random_word(), random_word(), fill);
            end
         end
         // A stretch of messages with no idling on either side.
         quiet = (msg >= 12 && msg < 20);
         msg_len = $urandom_range(1, 24);
         first_sop = ($urandom_range(0, 9) != 0);
         for (int b = 0; b < msg_len; b++) begin
            send_request(byte_type'($urandom_range(0, 255)),
                         (b == 0) ? first_sop : ($urandom_range(0, 99) < 3));
            random_sent++;
         end
         msg++;
      end
      quiet = 1'b0;
      end_burst();
      repeat (10) @(posedge clock);

      $display("Covered %0d requests, %0d of them starting a message, under %0d key settings.",
               requests_sent, messages_started, key_settings);
      $display("Responses saw random back-pressure and one hold-off of %0d cycles.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
